>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions; all use i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MVA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define MVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Types, codes and helpers shared by the voice allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

    localparam int VOICES_DEF = 5;   // default voice count (2 to 8)
    localparam int VIDX_W     = 3;   // width of the voice index field
    localparam int NOTE_W     = 7;
    localparam int BEND_W     = 16;
    localparam int PITCH_W    = 21;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_PITCH    = 2'd2,
        CMD_OTHER    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_HARD  = 3'd0,
        ACT_SOFT  = 3'd1,
        ACT_PITCH = 3'd2,
        ACT_GATE  = 3'd3,
        ACT_PASS  = 3'd4
    } t_act;

    // Controls broadcast from the sequencer to every voice cell.
    typedef struct packed {
        logic [NOTE_W-1:0] note;   // search key and allocation note
        logic              load;   // copy stored note into the shift stage
        logic              shift;  // move shift stage one cell toward cell 0
    } t_cell_ctl;

    // Note number plus sign-extended bend, in semitones with 12 fraction bits.
    function automatic logic [PITCH_W-1:0] pitch_of(
        input logic [NOTE_W-1:0] note,
        input logic [BEND_W-1:0] bend
    );
        logic [PITCH_W-1:0] base;
        logic [PITCH_W-1:0] ext;
        base = {2'b00, note, 12'h000};
        ext  = {{(PITCH_W - BEND_W){bend[BEND_W-1]}}, bend};
        return base + ext;
    endfunction

endpackage

`default_nettype wire

>>> src/midi_voice_allocator_top.sv
// A request is captured, looked up in S_LOOK, and its results are registered one at a time in S_EMIT.
// The block takes no new request until the last result of the current one is issued.
// A request yields 1 result for a regate or note-off, 4 for a new allocation and VOICES
// for bend or pass-through; a request on another channel or a note-off without a match yields none.
// Results pass one per cycle through one output register while the output is not stalled.
// Reset (synchronous, active low) clears all voices, the pointer, the bend and the channel.
// ----------------------------------------------------------------------------
// midi_voice_allocator_top
// Round-robin polyphonic voice allocator for decoded MIDI requests.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_voice_allocator_top #(
    parameter int VOICES = mva_pkg::VOICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Channel register write port.
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [3:0]                      i_cfg_wr_data,
    // Request stream.
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata from bit 0: channel[3:0], note[6:0], velocity[6:0],
    // bend_semitones[15:0], raw_status[7:0], raw_data1[6:0], raw_data2[6:0]
    input  wire logic [mva_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]                      i_s_tuser,
    // Voice action stream.
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata from bit 0: voice_index[2:0], pitch[20:0], gate_level[6:0],
    // fwd_status[7:0], fwd_data1[6:0], fwd_data2[6:0], zero padding[2:0]
    output logic [mva_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: action[2:0]
    output logic [2:0]                           o_m_tuser,
    output logic                                 o_m_tlast
);

    localparam int VW     = $clog2(VOICES);
    localparam int NOTE_W = mva_pkg::NOTE_W;

    // The voices form a row of cells. Two chains run through the row:
    // the lookup chain from cell 0 upward carries whether a lower voice
    // already matched and which one, so the lowest matching voice wins;
    // the shift chain toward cell 0 delivers stored notes one voice per
    // cycle, when the output is not stalled, while a pitch bend is broadcast.
    mva_pkg::t_cell_ctl       w_ctl;
    logic [VOICES-1:0]        w_wr_sel;
    logic [VOICES-1:0]        w_soft_sel;
    logic [VOICES:0]          w_hit;
    logic [VW-1:0]            w_hit_idx [VOICES+1];
    logic [NOTE_W-1:0]        w_shift   [VOICES+1];

    assign w_hit[0]        = 1'b0;
    assign w_hit_idx[0]    = '0;
    assign w_shift[VOICES] = '0;

    // The sequencer filters on channel, decides hit or allocation from the
    // end of the lookup chain, and issues one result per cycle unless stalled.
    mva_ctrl #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast),
        .o_ctl         (w_ctl),
        .o_wr_sel      (w_wr_sel),
        .o_soft_sel    (w_soft_sel),
        .i_hit         (w_hit[VOICES]),
        .i_hit_idx     (w_hit_idx[VOICES]),
        .i_shift_note  (w_shift[0])
    );

    for (genvar gi = 0; gi < VOICES; gi++) begin : g_voice
        mva_cell #(
            .VW     (VW),
            .MY_IDX (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_wr_sel     (w_wr_sel[gi]),
            .i_soft_sel   (w_soft_sel[gi]),
            .i_hit        (w_hit[gi]),
            .i_hit_idx    (w_hit_idx[gi]),
            .o_hit        (w_hit[gi+1]),
            .o_hit_idx    (w_hit_idx[gi+1]),
            .i_shift_note (w_shift[gi+1]),
            .o_shift_note (w_shift[gi])
        );
    end

endmodule

`default_nettype wire

>>> src/mva_cell.sv
// ----------------------------------------------------------------------------
// mva_cell
// One voice slot: stored note, soft reset flag, lookup link and shift stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_cell #(
    parameter int VW     = 3,
    parameter int MY_IDX = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mva_pkg::t_cell_ctl         i_ctl,
    input  wire logic                       i_wr_sel,
    input  wire logic                       i_soft_sel,
    input  wire logic                       i_hit,
    input  wire logic [VW-1:0]              i_hit_idx,
    output logic                            o_hit,
    output logic [VW-1:0]                   o_hit_idx,
    input  wire logic [mva_pkg::NOTE_W-1:0] i_shift_note,
    output logic [mva_pkg::NOTE_W-1:0]      o_shift_note
);

    logic [mva_pkg::NOTE_W-1:0] r_note;
    logic                       r_soft;
    logic [mva_pkg::NOTE_W-1:0] r_shift;
    logic                       w_match;

    // A voice in soft reset never answers a lookup.
    assign w_match   = (r_note == i_ctl.note) && !r_soft;
    assign o_hit     = i_hit | w_match;
    assign o_hit_idx = (!i_hit && w_match) ? VW'(MY_IDX) : i_hit_idx;
    assign o_shift_note = r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note <= '0;
            r_soft <= 1'b0;
        end else begin
            if (i_wr_sel) begin
                r_note <= i_ctl.note;
                r_soft <= 1'b0;
            end else if (i_soft_sel) begin
                r_soft <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift <= r_note;
        end else if (i_ctl.shift) begin
            r_shift <= i_shift_note;
        end
    end

endmodule

`default_nettype wire

>>> src/mva_ctrl.sv
// ----------------------------------------------------------------------------
// mva_ctrl
// Request capture, channel filter, allocation decisions and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mva_ctrl #(
    parameter int VOICES = mva_pkg::VOICES_DEF,
    parameter int VW     = $clog2(VOICES)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [3:0]                      i_cfg_wr_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [mva_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [1:0]                      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [mva_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [2:0]                           o_m_tuser,
    output logic                                 o_m_tlast,
    output mva_pkg::t_cell_ctl                   o_ctl,
    output logic [VOICES-1:0]                    o_wr_sel,
    output logic [VOICES-1:0]                    o_soft_sel,
    input  wire logic                            i_hit,
    input  wire logic [VW-1:0]                   i_hit_idx,
    input  wire logic [mva_pkg::NOTE_W-1:0]      i_shift_note
);

    localparam int VIDX_W  = mva_pkg::VIDX_W;
    localparam int NOTE_W  = mva_pkg::NOTE_W;
    localparam int PITCH_W = mva_pkg::PITCH_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                 r_state;
    logic [3:0]             r_midi_ch;
    logic [15:0]            r_bend;
    logic [VW-1:0]          r_next;
    logic                   r_alloc;
    logic [1:0]             r_step;
    logic [VW-1:0]          r_cnt;
    logic                   r_out_valid;

    mva_pkg::t_cmd          r_cmd;
    logic [NOTE_W-1:0]      r_note;
    logic [6:0]             r_vel;
    logic [7:0]             r_st;
    logic [6:0]             r_d1;
    logic [6:0]             r_d2;
    logic [VW-1:0]          r_tgt;
    logic [VW-1:0]          r_nv;

    logic [VIDX_W-1:0]      r_out_idx;
    mva_pkg::t_act          r_out_act;
    logic [PITCH_W-1:0]     r_out_pitch;
    logic [6:0]             r_out_gate;
    logic [7:0]             r_out_st;
    logic [6:0]             r_out_d1;
    logic [6:0]             r_out_d2;
    logic                   r_out_last;

    logic [VIDX_W-1:0]      n_out_idx;
    mva_pkg::t_act          n_out_act;
    logic [PITCH_W-1:0]     n_out_pitch;
    logic [6:0]             n_out_gate;
    logic [7:0]             n_out_st;
    logic [6:0]             n_out_d1;
    logic [6:0]             n_out_d2;
    logic                   n_out_last;

    // Input fields, lowest bits first: channel, note, velocity, bend,
    // raw status, raw data1, raw data2.
    logic [3:0]             w_in_ch;
    logic [NOTE_W-1:0]      w_in_note;
    logic [6:0]             w_in_vel;
    logic [15:0]            w_in_bend;
    logic [7:0]             w_in_st;
    logic [6:0]             w_in_d1;
    logic [6:0]             w_in_d2;

    logic                   w_in_acc;
    logic                   w_go;
    logic                   w_bcast;
    logic                   w_alloc_now;
    logic [VW-1:0]          w_nv;
    logic [NOTE_W-1:0]      w_pitch_note;

    assign w_in_ch   = i_s_tdata[3:0];
    assign w_in_note = i_s_tdata[10:4];
    assign w_in_vel  = i_s_tdata[17:11];
    assign w_in_bend = i_s_tdata[33:18];
    assign w_in_st   = i_s_tdata[41:34];
    assign w_in_d1   = i_s_tdata[48:42];
    assign w_in_d2   = i_s_tdata[55:49];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    assign w_bcast = (r_cmd == mva_pkg::CMD_PITCH) || (r_cmd == mva_pkg::CMD_OTHER);
    assign w_go    = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    assign w_nv    = (r_next == VW'(VOICES - 1)) ? '0 : r_next + VW'(1);

    // A note-on that matches no voice takes the round-robin voice.
    assign w_alloc_now = (r_state == S_LOOK) && (r_cmd == mva_pkg::CMD_NOTE_ON) && !i_hit;

    assign o_ctl.note  = r_note;
    assign o_ctl.load  = (r_state == S_LOOK);
    assign o_ctl.shift = w_go && w_bcast;

    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            o_wr_sel[i]   = w_alloc_now && (r_next == VW'(i));
            o_soft_sel[i] = w_alloc_now && (w_nv == VW'(i));
        end
    end

    assign w_pitch_note = w_bcast ? i_shift_note : r_note;

    always_comb begin
        n_out_idx   = VIDX_W'(r_tgt);
        n_out_act   = mva_pkg::ACT_GATE;
        n_out_pitch = '0;
        n_out_gate  = '0;
        n_out_st    = '0;
        n_out_d1    = '0;
        n_out_d2    = '0;
        n_out_last  = 1'b0;
        if (w_bcast) begin
            n_out_idx  = VIDX_W'(r_cnt);
            n_out_last = (r_cnt == VW'(VOICES - 1));
            if (r_cmd == mva_pkg::CMD_PITCH) begin
                n_out_act   = mva_pkg::ACT_PITCH;
                n_out_pitch = mva_pkg::pitch_of(w_pitch_note, r_bend);
            end else begin
                n_out_act = mva_pkg::ACT_PASS;
                n_out_st  = r_st;
                n_out_d1  = r_d1;
                n_out_d2  = r_d2;
            end
        end else if (r_alloc) begin
            case (r_step)
                2'd0: begin
                    n_out_act = mva_pkg::ACT_HARD;
                end
                2'd1: begin
                    n_out_act   = mva_pkg::ACT_PITCH;
                    n_out_pitch = mva_pkg::pitch_of(w_pitch_note, r_bend);
                end
                2'd2: begin
                    n_out_act = mva_pkg::ACT_SOFT;
                    n_out_idx = VIDX_W'(r_nv);
                end
                default: begin
                    n_out_gate = r_vel;
                    n_out_last = 1'b1;
                end
            endcase
        end else begin
            // Existing voice: note-on regates it, note-off closes the gate.
            n_out_gate = (r_cmd == mva_pkg::CMD_NOTE_ON) ? r_vel : 7'd0;
            n_out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_midi_ch   <= '0;
            r_bend      <= '0;
            r_next      <= '0;
            r_alloc     <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_midi_ch <= i_cfg_wr_data;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_in_ch == r_midi_ch)) begin
                        r_state <= S_LOOK;
                        if (mva_pkg::t_cmd'(i_s_tuser) == mva_pkg::CMD_PITCH) begin
                            r_bend <= w_in_bend;
                        end
                    end
                end
                S_LOOK: begin
                    r_step  <= '0;
                    r_cnt   <= '0;
                    r_alloc <= w_alloc_now;
                    if (w_alloc_now) begin
                        r_next <= w_nv;
                    end
                    if ((r_cmd == mva_pkg::CMD_NOTE_OFF) && !i_hit) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_go) begin
                        r_step <= r_step + 2'd1;
                        r_cnt  <= r_cnt + VW'(1);
                        if (n_out_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= mva_pkg::t_cmd'(i_s_tuser);
            r_note <= w_in_note;
            r_vel  <= w_in_vel;
            r_st   <= w_in_st;
            r_d1   <= w_in_d1;
            r_d2   <= w_in_d2;
        end
        if (r_state == S_LOOK) begin
            r_tgt <= i_hit ? i_hit_idx : r_next;
            r_nv  <= w_nv;
        end
        if (w_go) begin
            r_out_idx   <= n_out_idx;
            r_out_act   <= n_out_act;
            r_out_pitch <= n_out_pitch;
            r_out_gate  <= n_out_gate;
            r_out_st    <= n_out_st;
            r_out_d1    <= n_out_d1;
            r_out_d2    <= n_out_d2;
            r_out_last  <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_act;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {3'b000, r_out_d2, r_out_d1, r_out_st, r_out_gate,
                         r_out_pitch, r_out_idx};

    `MVA_ASSERT(a_alloc_distinct, (r_state == S_EMIT && r_alloc) |-> (r_nv != r_tgt), "allocated voice and soft-reset voice coincide")
    `MVA_ASSERT(a_next_in_range, r_next <= VW'(VOICES - 1), "round-robin pointer out of range")
    `MVA_ASSERT_NEXT(a_drop_stays_idle, (w_in_acc && (w_in_ch != r_midi_ch)), (r_state == S_IDLE), "request on another channel left idle")
    `MVA_ASSERT_NEXT(a_last_to_idle, (w_go && n_out_last), (r_state == S_IDLE && o_m_tvalid && o_m_tlast), "final result did not end the request")

endmodule

`default_nettype wire
